@@ rtl/core/i2c_srb_pkg.sv @@
// Shared types, constants and codes for the I2C slave register bank.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package i2c_srb_pkg;

  localparam int MEM_DEPTH = 256;
  localparam int PTR_W     = $clog2(MEM_DEPTH);
  localparam int CFG_W     = 9;

  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [PTR_W-1:0] ptr_t;

  localparam cfg_word_t DEPTH_CFG = cfg_word_t'(MEM_DEPTH);
  localparam cfg_word_t SIZE_RST  = cfg_word_t'(256);

  typedef enum logic [2:0] {
    ACT_ADDR_WRITE  = 3'd0,
    ACT_DATA_RX     = 3'd1,
    ACT_ADDR_READ   = 3'd2,
    ACT_TX_ACK      = 3'd3,
    ACT_XFER_END    = 3'd4,
    ACT_LOCAL_WRITE = 3'd5,
    ACT_LOCAL_READ  = 3'd6,
    ACT_SET_LPTR    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_RESP = 2'd2
  } ctl_state_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       busy_res;
    logic       transfer_done;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic respond;
  } ctl_cmd_t;

endpackage

@@ rtl/core/i2c_srb_ctrl.sv @@
// Sequencer for the register bank: capture, execute, respond.
// Depends on i2c_srb_pkg; drives the datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module i2c_srb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output i2c_srb_pkg::ctl_cmd_t  cmd
);

  i2c_srb_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2c_srb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2c_srb_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = i2c_srb_pkg::ST_EXEC;
        end
      end
      i2c_srb_pkg::ST_EXEC: state_nxt = i2c_srb_pkg::ST_RESP;
      i2c_srb_pkg::ST_RESP: state_nxt = i2c_srb_pkg::ST_IDLE;
      default:              state_nxt = i2c_srb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      i2c_srb_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      i2c_srb_pkg::ST_EXEC: cmd.exec    = 1'b1;
      i2c_srb_pkg::ST_RESP: cmd.respond = 1'b1;
      default:              busy        = 1'b1;
    endcase
  end

endmodule

@@ rtl/core/i2c_srb_dp.sv @@
// Datapath of the register bank: byte store, pointers, bus phase, size register.
// Depends on i2c_srb_pkg; sequenced by i2c_srb_ctrl through ctl_cmd_t.
`timescale 1ns / 1ps

module i2c_srb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  i2c_srb_pkg::ctl_cmd_t             cmd,
  input  i2c_srb_pkg::in_item_t             in_data,
  input  logic                              cfg_we,
  input  logic [i2c_srb_pkg::CFG_W-1:0]     cfg_data,
  output i2c_srb_pkg::out_item_t            out_data
);

  // byte store and its written flags (unwritten entries read as zero)
  logic [7:0]                          mem [i2c_srb_pkg::MEM_DEPTH];
  logic [i2c_srb_pkg::MEM_DEPTH-1:0]   wr_vld_r;

  i2c_srb_pkg::in_item_t   item_r;
  i2c_srb_pkg::cfg_word_t  size_r;
  i2c_srb_pkg::phase_t     phase_r, phase_nxt;
  i2c_srb_pkg::ptr_t       rptr_r, rptr_nxt;
  i2c_srb_pkg::ptr_t       lptr_r, lptr_nxt;

  logic [7:0] rdata_r;
  logic       rvld_r;
  logic       rd_sel_r, rd_sel_nxt;
  logic       busy_r, done_r, rej_r;
  logic       done_nxt, rej_nxt;

  i2c_srb_pkg::cfg_word_t  eff;
  i2c_srb_pkg::cfg_word_t  d_ext;
  i2c_srb_pkg::ptr_t       acc_addr;
  i2c_srb_pkg::ptr_t       rptr_adv, lptr_adv;
  logic                    mem_we;
  logic                    d_fits;

  function automatic i2c_srb_pkg::ptr_t advance(input i2c_srb_pkg::ptr_t p,
                                                input i2c_srb_pkg::cfg_word_t sz);
    i2c_srb_pkg::cfg_word_t n;
    n = i2c_srb_pkg::cfg_word_t'(p) + i2c_srb_pkg::cfg_word_t'(1);
    return (n >= sz) ? '0 : n[i2c_srb_pkg::PTR_W-1:0];
  endfunction

  // saturate to the store depth, treat zero as one
  always_comb begin
    if (size_r > i2c_srb_pkg::DEPTH_CFG) begin
      eff = i2c_srb_pkg::DEPTH_CFG;
    end else if (size_r == '0) begin
      eff = i2c_srb_pkg::cfg_word_t'(1);
    end else begin
      eff = size_r;
    end
  end

  assign d_ext    = i2c_srb_pkg::cfg_word_t'(item_r.data_in);
  assign d_fits   = d_ext < eff;
  assign rptr_adv = advance(rptr_r, eff);
  assign lptr_adv = advance(lptr_r, eff);

  always_comb begin
    phase_nxt  = phase_r;
    rptr_nxt   = rptr_r;
    lptr_nxt   = lptr_r;
    acc_addr   = rptr_r;
    mem_we     = 1'b0;
    rd_sel_nxt = 1'b0;
    done_nxt   = 1'b0;
    rej_nxt    = 1'b0;
    case (item_r.action)
      i2c_srb_pkg::ACT_ADDR_WRITE: phase_nxt = i2c_srb_pkg::PH_ADDR;
      i2c_srb_pkg::ACT_DATA_RX: begin
        if (phase_r == i2c_srb_pkg::PH_ADDR) begin
          // replace an out-of-range pointer byte by zero
          rptr_nxt  = d_fits ? item_r.data_in[i2c_srb_pkg::PTR_W-1:0] : '0;
          phase_nxt = i2c_srb_pkg::PH_DATA;
        end else begin
          mem_we   = 1'b1;
          rptr_nxt = rptr_adv;
        end
      end
      i2c_srb_pkg::ACT_ADDR_READ: begin
        phase_nxt  = i2c_srb_pkg::PH_DATA;
        rd_sel_nxt = 1'b1;
        rptr_nxt   = rptr_adv;
      end
      i2c_srb_pkg::ACT_TX_ACK: begin
        rd_sel_nxt = 1'b1;
        rptr_nxt   = rptr_adv;
      end
      i2c_srb_pkg::ACT_XFER_END: begin
        phase_nxt = i2c_srb_pkg::PH_IDLE;
        done_nxt  = 1'b1;
      end
      i2c_srb_pkg::ACT_LOCAL_WRITE: begin
        acc_addr = lptr_r;
        mem_we   = 1'b1;
        lptr_nxt = lptr_adv;
      end
      i2c_srb_pkg::ACT_LOCAL_READ: begin
        acc_addr   = lptr_r;
        rd_sel_nxt = 1'b1;
        lptr_nxt   = lptr_adv;
      end
      i2c_srb_pkg::ACT_SET_LPTR: begin
        if (d_fits) begin
          lptr_nxt = item_r.data_in[i2c_srb_pkg::PTR_W-1:0];
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= i2c_srb_pkg::SIZE_RST;
      phase_r  <= i2c_srb_pkg::PH_IDLE;
      rptr_r   <= '0;
      lptr_r   <= '0;
      wr_vld_r <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_data;
      end
      if (cmd.exec) begin
        phase_r <= phase_nxt;
        rptr_r  <= rptr_nxt;
        lptr_r  <= lptr_nxt;
        if (mem_we) begin
          wr_vld_r[acc_addr] <= 1'b1;
        end
      end
    end
  end

  // store port: one write or one registered read per executed item
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[acc_addr] <= item_r.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata_r  <= mem[acc_addr];
      rvld_r   <= wr_vld_r[acc_addr];
      rd_sel_r <= rd_sel_nxt;
      busy_r   <= (phase_nxt != i2c_srb_pkg::PH_IDLE);
      done_r   <= done_nxt;
      rej_r    <= rej_nxt;
    end
  end

  always_comb begin
    out_data               = '0;
    out_data.data_out      = (cmd.respond && rd_sel_r && rvld_r) ? rdata_r : 8'h00;
    out_data.busy_res      = cmd.respond && busy_r;
    out_data.transfer_done = cmd.respond && done_r;
    out_data.rejected      = cmd.respond && rej_r;
  end

endmodule

@@ rtl/core/i2c_slave_register_bank.sv @@
// Top level of the I2C slave register bank: sequencer plus datapath.
// Depends on i2c_srb_pkg, i2c_srb_ctrl and i2c_srb_dp.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------
//   input    | start high, busy low      | in_data  (in_item_t)
//   result   | out_valid strobe, 1 cycle | out_data (out_item_t)
//   config   | cfg_valid and cfg_ready   | cfg_data (mem_size, 9 bits)
//
// Each transaction runs through three steps: accept, execute (one store access), respond.
// The result is shown in the respond step, after the execute step; busy stays high until it is shown.
// The store has a single port, so an item reads or writes exactly one byte.
// Reset is synchronous, active low; the store reads as zero until written.
// The receiver cannot stall; cfg_ready is high whenever the block is idle.
`timescale 1ns / 1ps

module i2c_slave_register_bank (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  i2c_srb_pkg::in_item_t          in_data,
  output logic                           out_valid,
  output i2c_srb_pkg::out_item_t         out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [i2c_srb_pkg::CFG_W-1:0]  cfg_data
);

  i2c_srb_pkg::ctl_cmd_t cmd;

  i2c_srb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  i2c_srb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  assign cfg_ready = !busy;
  assign out_valid = cmd.respond;

endmodule

@@ rtl/core/i2c_srb_chk.sv @@
// Port-level checker for the register bank, bound to the top level.
// Depends on i2c_srb_pkg and i2c_slave_register_bank.
`timescale 1ns / 1ps

module i2c_srb_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input i2c_srb_pkg::out_item_t  out_data
);

  // every accepted transaction yields its result once the execute step has passed
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result missing two cycles after acceptance");

  // the block holds off new transactions until the result is shown
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("not busy in the cycle after acceptance");

  // a result is a one-cycle strobe and frees the block
  a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle or block stays busy");

  // an end-of-transfer result carries no byte, no rejection and an idle bus
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.transfer_done |->
      out_data.data_out == 8'h00 && !out_data.rejected && !out_data.busy_res)
    else $error("end-of-transfer result with stray fields");

endmodule

bind i2c_slave_register_bank i2c_srb_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
